[src/ffa_pkg.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ffa_pkg
// Shared sizes, codes and types for the first-fit free-list allocator.
// -----------------------------------------------------------------------------
package ffa_pkg;

   localparam int FREE_SLOTS   = 16;
   localparam int ALLOC_SLOTS  = 16;
   localparam int HEADER_BYTES = 8;

   localparam int ADDR_W    = 32;
   localparam int ADJ_W     = 8;
   localparam int LIVE_W    = 5;
   localparam int CSR_IDX_W = 1;
   localparam int IDX_W     = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
   localparam int CNT_W     = $clog2(FREE_SLOTS + 1);
   localparam int SLOT_W    = (ALLOC_SLOTS > 1) ? $clog2(ALLOC_SLOTS) : 1;

   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BASE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BYTES = 1'b1;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NO_FIT  = 2'd1,
      ST_FULL    = 2'd2,
      ST_UNKNOWN = 2'd3
   } status_type;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } command_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_WRITE,
      CELL_REMOVE,
      CELL_JOIN,
      CELL_INSERT
   } cell_op_type;

   typedef struct packed {
      cell_op_type       op;
      logic [IDX_W-1:0]  index;
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] length;
   } cell_cmd_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] slot;
      logic [ADDR_W-1:0] address;
      logic [ADDR_W-1:0] length;
      logic [ADJ_W-1:0]  adjust;
   } rec_write_type;

   typedef enum logic [2:0] {
      FSM_INIT,
      FSM_IDLE,
      FSM_ALLOC_ADJ,
      FSM_ALLOC_FIT,
      FSM_FREE_READ,
      FSM_FREE_SCAN,
      FSM_FREE_APPLY,
      FSM_REPLY
   } fsm_type;

endpackage

[src/ffa_extent_cell.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ffa_extent_cell
// One free extent; shifts with its neighbours on insert and remove.
// -----------------------------------------------------------------------------
module ffa_extent_cell import ffa_pkg::*; (
   input  logic              clock,
   input  cell_cmd_type      cmd,
   input  logic [IDX_W-1:0]  my_index,
   input  logic [ADDR_W-1:0] left_start,
   input  logic [ADDR_W-1:0] left_length,
   input  logic [ADDR_W-1:0] right_start,
   input  logic [ADDR_W-1:0] right_length,
   output logic [ADDR_W-1:0] start,
   output logic [ADDR_W-1:0] length
);

   logic [ADDR_W-1:0] start_ff, start_in;
   logic [ADDR_W-1:0] length_ff, length_in;
   logic              below;

   assign below = ({1'b0, my_index} + 1'b1) == {1'b0, cmd.index};

   always_comb begin
      start_in  = start_ff;
      length_in = length_ff;
      unique case (cmd.op)
         CELL_WRITE: begin
            if (my_index == cmd.index) begin
               start_in  = cmd.start;
               length_in = cmd.length;
            end
         end
         CELL_REMOVE, CELL_JOIN: begin
            if (my_index >= cmd.index) begin
               start_in  = right_start;
               length_in = right_length;
            end else if (cmd.op == CELL_JOIN && below) begin
               start_in  = cmd.start;
               length_in = cmd.length;
            end
         end
         CELL_INSERT: begin
            if (my_index > cmd.index) begin
               start_in  = left_start;
               length_in = left_length;
            end else if (my_index == cmd.index) begin
               start_in  = cmd.start;
               length_in = cmd.length;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      start_ff  <= start_in;
      length_ff <= length_in;
   end

   assign start  = start_ff;
   assign length = length_ff;

endmodule

[src/ffa_record_table.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ffa_record_table
// Allocation records: address, total size and adjustment per live allocation.
// -----------------------------------------------------------------------------
module ffa_record_table import ffa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              clear_all,
   input  rec_write_type     wr,
   input  logic              clr_en,
   input  logic [SLOT_W-1:0] clr_slot,
   input  logic [ADDR_W-1:0] lookup_address,
   output logic              hit,
   output logic [SLOT_W-1:0] hit_slot,
   output logic              full,
   output logic [SLOT_W-1:0] free_slot,
   input  logic              rd_en,
   output logic [ADDR_W-1:0] rd_length,
   output logic [ADJ_W-1:0]  rd_adjust
);

   logic [ADDR_W-1:0]      rec_address_ff [ALLOC_SLOTS];
   logic [ADDR_W-1:0]      rec_length_ff  [ALLOC_SLOTS];
   logic [ADJ_W-1:0]       rec_adjust_ff  [ALLOC_SLOTS];
   logic [ALLOC_SLOTS-1:0] valid_ff, valid_in;
   logic [ADDR_W-1:0]      rd_length_ff;
   logic [ADJ_W-1:0]       rd_adjust_ff;

   always_comb begin
      hit      = 1'b0;
      hit_slot = '0;
      full     = 1'b1;
      free_slot = '0;
      for (int k = ALLOC_SLOTS - 1; k >= 0; k--) begin
         if (valid_ff[k] && rec_address_ff[k] == lookup_address) begin
            hit      = 1'b1;
            hit_slot = SLOT_W'(k);
         end
         if (!valid_ff[k]) begin
            full      = 1'b0;
            free_slot = SLOT_W'(k);
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.slot] = 1'b1;
      end
      if (clr_en) begin
         valid_in[clr_slot] = 1'b0;
      end
      if (clear_all) begin
         valid_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         rec_address_ff[wr.slot] <= wr.address;
         rec_length_ff[wr.slot]  <= wr.length;
         rec_adjust_ff[wr.slot]  <= wr.adjust;
      end
      if (rd_en) begin
         rd_length_ff <= rec_length_ff[hit_slot];
         rd_adjust_ff <= rec_adjust_ff[hit_slot];
      end
   end

   assign rd_length = rd_length_ff;
   assign rd_adjust = rd_adjust_ff;

endmodule

[src/first_fit_free_list_allocator_core.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// first_fit_free_list_allocator_core
// First-fit allocator over a row of free-extent cells with coalescing on free.
// -----------------------------------------------------------------------------
// One request at a time. An allocate passes the adjust and fit states for each
// extent examined, then replies; a free reads its record, scans the extents by
// address, applies the merge or insert, then replies. The free scan reads one
// cell per cycle; both scans use a single read mux. A reset or any register
// write reloads the pool as one extent, during which no request is taken.
// -----------------------------------------------------------------------------
module first_fit_free_list_allocator_core import ffa_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_command,
   input  logic [ADDR_W-1:0]    req_request_bytes,
   input  logic [7:0]           req_align_bytes,
   input  logic [ADDR_W-1:0]    req_free_address,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status,
   output logic [ADDR_W-1:0]    rsp_granted_address,
   output logic [ADDR_W-1:0]    rsp_bytes_in_use,
   output logic [LIVE_W-1:0]    rsp_live_allocations,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_write_data
);

   fsm_type           state_ff, state_in;
   logic [ADDR_W-1:0] base_ff, base_in, bytes_ff, bytes_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in, i_ff, i_in;
   logic [ADDR_W-1:0] used_ff, used_in;
   logic [LIVE_W-1:0] tally_ff, tally_in;
   logic [ADDR_W-1:0] req_ff, req_in, addr_ff, addr_in;
   logic [7:0]        mask_ff, mask_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [ADJ_W-1:0]  adj_ff, adj_in;
   logic [ADDR_W:0]   total_ff, total_in;
   logic [ADDR_W-1:0] cur_start_ff, cur_start_in, cur_len_ff, cur_len_in;
   logic [ADDR_W-1:0] bstart_ff, bstart_in, bsize_ff, bsize_in;
   logic [ADDR_W:0]   bend_ff, bend_in, prev_end_ff, prev_end_in;
   logic [ADDR_W-1:0] prev_start_ff, prev_start_in, prev_len_ff, prev_len_in;
   logic              mnext_ff, mnext_in;
   status_type        res_status_ff, res_status_in;
   logic [ADDR_W-1:0] res_granted_ff, res_granted_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0] rsp_granted_ff, rsp_granted_in, rsp_used_ff, rsp_used_in;
   logic [LIVE_W-1:0] rsp_live_ff, rsp_live_in;

   cell_cmd_type      cell_cmd;
   rec_write_type     rec_wr;
   logic              rec_clear, rec_clr_en, rec_hit, rec_full, rec_rd_en;
   logic [SLOT_W-1:0] rec_hit_slot, rec_free_slot;
   logic [ADDR_W-1:0] rec_rd_length;
   logic [ADJ_W-1:0]  rec_rd_adjust;

   logic [ADDR_W-1:0] cell_start [FREE_SLOTS];
   logic [ADDR_W-1:0] cell_length [FREE_SLOTS];
   logic [ADDR_W-1:0] sel_start, sel_length;
   logic [IDX_W-1:0]  idx;
   logic [ADDR_W:0]   room;
   logic [ADDR_W-1:0] pool_len;
   logic [7:0]        align_mask;
   logic [ADJ_W-1:0]  adj_calc;
   logic [ADDR_W-1:0] rem;
   logic              mprev, accept;

   function automatic logic [ADJ_W-1:0] adjust_for(input logic [7:0] low,
                                                   input logic [7:0] mask);
      logic [8:0] adj0;
      logic [8:0] need;
      logic [8:0] adj;
      adj0 = {1'b0, (~low + 8'd1) & mask};
      adj  = adj0;
      if (adj0 < 9'(HEADER_BYTES)) begin
         need = 9'(HEADER_BYTES) - adj0;
         adj  = adj0 + ((need + {1'b0, mask}) & ~{1'b0, mask});
      end
      return adj[ADJ_W-1:0];
   endfunction

   for (genvar k = 0; k < FREE_SLOTS; k++) begin : g_cell
      logic [ADDR_W-1:0] l_start, l_length, r_start, r_length;
      if (k == 0) begin : g_first
         assign l_start  = '0;
         assign l_length = '0;
      end else begin : g_mid
         assign l_start  = cell_start[k-1];
         assign l_length = cell_length[k-1];
      end
      if (k == FREE_SLOTS - 1) begin : g_last
         assign r_start  = '0;
         assign r_length = '0;
      end else begin : g_inner
         assign r_start  = cell_start[k+1];
         assign r_length = cell_length[k+1];
      end
      ffa_extent_cell u_cell (
         .clock        (clock),
         .cmd          (cell_cmd),
         .my_index     (IDX_W'(k)),
         .left_start   (l_start),
         .left_length  (l_length),
         .right_start  (r_start),
         .right_length (r_length),
         .start        (cell_start[k]),
         .length       (cell_length[k])
      );
   end

   ffa_record_table u_records (
      .clock          (clock),
      .reset          (reset),
      .clear_all      (rec_clear),
      .wr             (rec_wr),
      .clr_en         (rec_clr_en),
      .clr_slot       (slot_ff),
      .lookup_address (req_free_address),
      .hit            (rec_hit),
      .hit_slot       (rec_hit_slot),
      .full           (rec_full),
      .free_slot      (rec_free_slot),
      .rd_en          (rec_rd_en),
      .rd_length      (rec_rd_length),
      .rd_adjust      (rec_rd_adjust)
   );

   assign idx        = i_ff[IDX_W-1:0];
   assign sel_start  = cell_start[idx];
   assign sel_length = cell_length[idx];
   assign room       = {1'b1, {ADDR_W{1'b0}}} - {1'b0, base_ff};
   assign pool_len   = ({1'b0, bytes_ff} > room) ? room[ADDR_W-1:0] : bytes_ff;
   assign adj_calc   = adjust_for(sel_start[7:0], mask_ff);
   assign rem        = cur_len_ff - total_ff[ADDR_W-1:0];
   assign mprev      = (i_ff != '0) && (prev_end_ff == {1'b0, bstart_ff});
   assign req_ready  = (state_ff == FSM_IDLE);
   assign accept     = req_valid && req_ready;
   assign rec_rd_en  = accept;

   always_comb begin
      align_mask = 8'd0;
      for (int b = 0; b < 8; b++) begin
         if (req_align_bytes[b]) begin
            align_mask = 8'((9'd1 << b) - 9'd1);
         end
      end
   end

   always_comb begin
      base_in  = base_ff;
      bytes_in = bytes_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_POOL_BASE:  base_in  = csr_write_data;
            CSR_POOL_BYTES: bytes_in = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      i_in           = i_ff;
      used_in        = used_ff;
      tally_in       = tally_ff;
      req_in         = req_ff;
      addr_in        = addr_ff;
      mask_in        = mask_ff;
      slot_in        = slot_ff;
      adj_in         = adj_ff;
      total_in       = total_ff;
      cur_start_in   = cur_start_ff;
      cur_len_in     = cur_len_ff;
      bstart_in      = bstart_ff;
      bsize_in       = bsize_ff;
      bend_in        = bend_ff;
      prev_end_in    = prev_end_ff;
      prev_start_in  = prev_start_ff;
      prev_len_in    = prev_len_ff;
      mnext_in       = mnext_ff;
      res_status_in  = res_status_ff;
      res_granted_in = res_granted_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_used_in    = rsp_used_ff;
      rsp_live_in    = rsp_live_ff;
      cell_cmd       = '{op: CELL_HOLD, index: idx, start: '0, length: '0};
      rec_wr         = '{en: 1'b0, slot: slot_ff, address: '0, length: '0, adjust: '0};
      rec_clear      = 1'b0;
      rec_clr_en     = 1'b0;

      unique case (state_ff)
         FSM_INIT: begin
            cell_cmd  = '{op: CELL_WRITE, index: '0, start: base_ff, length: pool_len};
            cnt_in    = CNT_W'(1);
            used_in   = '0;
            tally_in  = '0;
            rec_clear = 1'b1;
            state_in  = FSM_IDLE;
         end
         FSM_IDLE: begin
            if (accept) begin
               req_in         = (req_request_bytes == '0) ? ADDR_W'(1) : req_request_bytes;
               mask_in        = align_mask;
               addr_in        = req_free_address;
               i_in           = '0;
               prev_end_in    = '0;
               res_granted_in = '0;
               if (command_type'(req_command) == CMD_ALLOC) begin
                  slot_in = rec_free_slot;
                  if (rec_full) begin
                     res_status_in = ST_FULL;
                     state_in      = FSM_REPLY;
                  end else begin
                     state_in = FSM_ALLOC_ADJ;
                  end
               end else begin
                  slot_in = rec_hit_slot;
                  if (!rec_hit) begin
                     res_status_in = ST_UNKNOWN;
                     state_in      = FSM_REPLY;
                  end else begin
                     state_in = FSM_FREE_READ;
                  end
               end
            end
         end
         FSM_ALLOC_ADJ: begin
            if (i_ff >= cnt_ff) begin
               res_status_in = ST_NO_FIT;
               state_in      = FSM_REPLY;
            end else begin
               adj_in       = adj_calc;
               total_in     = {1'b0, req_ff} + (ADDR_W + 1)'(adj_calc);
               cur_start_in = sel_start;
               cur_len_in   = sel_length;
               state_in     = FSM_ALLOC_FIT;
            end
         end
         FSM_ALLOC_FIT: begin
            if ({1'b0, cur_len_ff} < total_ff) begin
               i_in     = i_ff + 1'b1;
               state_in = FSM_ALLOC_ADJ;
            end else begin
               if (rem <= ADDR_W'(HEADER_BYTES)) begin
                  cell_cmd  = '{op: CELL_REMOVE, index: idx, start: '0, length: '0};
                  cnt_in    = cnt_ff - 1'b1;
                  rec_wr.length = cur_len_ff;
                  used_in   = used_ff + cur_len_ff;
               end else begin
                  cell_cmd = '{op: CELL_WRITE, index: idx,
                               start: cur_start_ff + total_ff[ADDR_W-1:0], length: rem};
                  rec_wr.length = total_ff[ADDR_W-1:0];
                  used_in  = used_ff + total_ff[ADDR_W-1:0];
               end
               rec_wr.en      = 1'b1;
               rec_wr.address = cur_start_ff + ADDR_W'(adj_ff);
               rec_wr.adjust  = adj_ff;
               tally_in       = tally_ff + 1'b1;
               res_granted_in = cur_start_ff + ADDR_W'(adj_ff);
               res_status_in  = ST_OK;
               state_in       = FSM_REPLY;
            end
         end
         FSM_FREE_READ: begin
            bstart_in = addr_ff - ADDR_W'(rec_rd_adjust);
            bsize_in  = rec_rd_length;
            bend_in   = {1'b0, addr_ff - ADDR_W'(rec_rd_adjust)} + {1'b0, rec_rd_length};
            state_in  = FSM_FREE_SCAN;
         end
         FSM_FREE_SCAN: begin
            if (i_ff < cnt_ff) begin
               if ({1'b0, sel_start} >= bend_ff) begin
                  mnext_in   = ({1'b0, sel_start} == bend_ff);
                  cur_len_in = sel_length;
                  state_in   = FSM_FREE_APPLY;
               end else begin
                  prev_end_in   = {1'b0, sel_start} + {1'b0, sel_length};
                  prev_start_in = sel_start;
                  prev_len_in   = sel_length;
                  i_in          = i_ff + 1'b1;
               end
            end else begin
               mnext_in = 1'b0;
               state_in = FSM_FREE_APPLY;
            end
         end
         FSM_FREE_APPLY: begin
            res_status_in = ST_OK;
            if (mprev && mnext_ff) begin
               cell_cmd = '{op: CELL_JOIN, index: idx, start: prev_start_ff,
                            length: prev_len_ff + bsize_ff + cur_len_ff};
               cnt_in   = cnt_ff - 1'b1;
            end else if (mprev) begin
               cell_cmd = '{op: CELL_WRITE, index: IDX_W'(i_ff - 1'b1),
                            start: prev_start_ff, length: prev_len_ff + bsize_ff};
            end else if (mnext_ff) begin
               cell_cmd = '{op: CELL_WRITE, index: idx, start: bstart_ff,
                            length: cur_len_ff + bsize_ff};
            end else if (cnt_ff >= CNT_W'(FREE_SLOTS)) begin
               res_status_in = ST_FULL;
            end else begin
               cell_cmd = '{op: CELL_INSERT, index: idx, start: bstart_ff, length: bsize_ff};
               cnt_in   = cnt_ff + 1'b1;
            end
            if (res_status_in == ST_OK) begin
               rec_clr_en = 1'b1;
               used_in    = used_ff - bsize_ff;
               tally_in   = tally_ff - 1'b1;
            end
            state_in = FSM_REPLY;
         end
         FSM_REPLY: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_granted_in = res_granted_ff;
               rsp_used_in    = used_ff;
               rsp_live_in    = tally_ff;
               state_in       = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_INIT;
         end
      endcase

      if (csr_write_enable) begin
         state_in = FSM_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_INIT;
         base_ff      <= '0;
         bytes_ff     <= ADDR_W'(65536);
         cnt_ff       <= CNT_W'(1);
         used_ff      <= '0;
         tally_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         bytes_ff     <= bytes_in;
         cnt_ff       <= cnt_in;
         used_ff      <= used_in;
         tally_ff     <= tally_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff           <= i_in;
      req_ff         <= req_in;
      addr_ff        <= addr_in;
      mask_ff        <= mask_in;
      slot_ff        <= slot_in;
      adj_ff         <= adj_in;
      total_ff       <= total_in;
      cur_start_ff   <= cur_start_in;
      cur_len_ff     <= cur_len_in;
      bstart_ff      <= bstart_in;
      bsize_ff       <= bsize_in;
      bend_ff        <= bend_in;
      prev_end_ff    <= prev_end_in;
      prev_start_ff  <= prev_start_in;
      prev_len_ff    <= prev_len_in;
      mnext_ff       <= mnext_in;
      res_status_ff  <= res_status_in;
      res_granted_ff <= res_granted_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_used_ff    <= rsp_used_in;
      rsp_live_ff    <= rsp_live_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_granted_address  = rsp_granted_ff;
   assign rsp_bytes_in_use     = rsp_used_ff;
   assign rsp_live_allocations = rsp_live_ff;

endmodule

[src/ffa_checker.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ffa_checker
// Port-level checks for the allocator core, bound to the top level.
// -----------------------------------------------------------------------------
module ffa_checker import ffa_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [1:0]           rsp_status,
   input logic [ADDR_W-1:0]    rsp_granted_address,
   input logic [LIVE_W-1:0]    rsp_live_allocations
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid && !req_ready)
      else $error("response or ready after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_granted_address))
      else $error("stalled response changed");

   a_fail_no_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_granted_address == '0)
      else $error("failed request carries an address");

   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_live_allocations <= LIVE_W'(ALLOC_SLOTS))
      else $error("live allocations exceed record slots");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

endmodule

bind first_fit_free_list_allocator_core ffa_checker u_ffa_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_ready            (req_ready),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_status           (rsp_status),
   .rsp_granted_address  (rsp_granted_address),
   .rsp_live_allocations (rsp_live_allocations)
);

[tb/sv/tb_first_fit_free_list_allocator_core.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_first_fit_free_list_allocator_core
// Drives allocate and free requests into the allocator under random idling and
// checks every response against a built-in model of the extent and record
// tables, over several pool settings written between phases.
// -----------------------------------------------------------------------------

class alloc_scoreboard;
   logic [31:0] pool_base;
   logic [31:0] pool_bytes;
   logic [31:0] ext_start [ffa_pkg::FREE_SLOTS];
   logic [31:0] ext_len [ffa_pkg::FREE_SLOTS];
   int          ext_count;
   logic [31:0] rec_addr [ffa_pkg::ALLOC_SLOTS];
   logic [31:0] rec_len [ffa_pkg::ALLOC_SLOTS];
   logic [7:0]  rec_adj [ffa_pkg::ALLOC_SLOTS];
   bit          rec_live [ffa_pkg::ALLOC_SLOTS];
   logic [31:0] used_bytes;
   int          live_count;
   logic [1:0]  want_status [$];
   logic [31:0] want_addr [$];
   logic [31:0] want_used [$];
   logic [4:0]  want_live [$];
   int          errors;

   function new();
      pool_base = 0;
      pool_bytes = 65536;
      errors = 0;
      rebuild_pool();
   endfunction

   function void rebuild_pool();
      longint unsigned room;
      room = 64'h1_0000_0000 - pool_base;
      for (int k = 0; k < ffa_pkg::FREE_SLOTS; k++) begin
         ext_start[k] = 0;
         ext_len[k] = 0;
      end
      for (int k = 0; k < ffa_pkg::ALLOC_SLOTS; k++) begin
         rec_live[k] = 0;
         rec_addr[k] = 0;
      end
      ext_start[0] = pool_base;
      ext_len[0] = (pool_bytes > room) ? room[31:0] : pool_bytes;
      ext_count = 1;
      used_bytes = 0;
      live_count = 0;
   endfunction

   function void write_reg(logic idx, logic [31:0] value);
      if (idx == ffa_pkg::CSR_POOL_BASE) pool_base = value;
      else pool_bytes = value;
      rebuild_pool();
   endfunction

   function longint unsigned header_gap(logic [31:0] addr, longint unsigned align);
      longint unsigned adj, need;
      adj = (align - (addr & (align - 1))) & (align - 1);
      if (adj < ffa_pkg::HEADER_BYTES) begin
         need = ffa_pkg::HEADER_BYTES - adj;
         adj += align * (need / align);
         if (need % align != 0) adj += align;
      end
      return adj;
   endfunction

   function void drop_extent(int i);
      for (int k = i; k + 1 < ext_count; k++) begin
         ext_start[k] = ext_start[k+1];
         ext_len[k] = ext_len[k+1];
      end
      ext_count--;
   endfunction

   function logic [1:0] allocate(logic [31:0] req_in, logic [7:0] align_in,
                                 output logic [31:0] granted);
      longint unsigned req, align, adj, total, len;
      int slot;
      granted = 0;
      req = (req_in == 0) ? 1 : req_in;
      align = 1;
      for (int i = 0; i < 8; i++) if (align_in[i]) align = 1 << i;
      slot = -1;
      for (int s = ffa_pkg::ALLOC_SLOTS - 1; s >= 0; s--) if (!rec_live[s]) slot = s;
      if (slot < 0) return ffa_pkg::ST_FULL;
      for (int i = 0; i < ext_count; i++) begin
         adj = header_gap(ext_start[i], align);
         total = req + adj;
         len = ext_len[i];
         if (len < total) continue;
         granted = ext_start[i] + adj[31:0];
         if (len - total <= ffa_pkg::HEADER_BYTES) begin
            total = len;
            drop_extent(i);
         end else begin
            ext_start[i] = ext_start[i] + total[31:0];
            ext_len[i] = len - total;
         end
         rec_addr[slot] = granted;
         rec_len[slot] = total[31:0];
         rec_adj[slot] = adj[7:0];
         rec_live[slot] = 1;
         used_bytes += total[31:0];
         live_count++;
         return ffa_pkg::ST_OK;
      end
      return ffa_pkg::ST_NO_FIT;
   endfunction

   function logic [1:0] release_block(logic [31:0] addr);
      longint unsigned bstart, bend, bsize;
      int slot, i;
      bit jp, jn;
      slot = -1;
      for (int s = ffa_pkg::ALLOC_SLOTS - 1; s >= 0; s--)
         if (rec_live[s] && rec_addr[s] == addr) slot = s;
      if (slot < 0) return ffa_pkg::ST_UNKNOWN;
      bstart = longint'(addr) - rec_adj[slot];
      bsize = rec_len[slot];
      bend = bstart + bsize;
      for (i = 0; i < ext_count; i++) if (longint'(ext_start[i]) >= bend) break;
      jp = i > 0 && longint'(ext_start[i-1]) + ext_len[i-1] == bstart;
      jn = i < ext_count && longint'(ext_start[i]) == bend;
      if (!jp && !jn && ext_count >= ffa_pkg::FREE_SLOTS) return ffa_pkg::ST_FULL;
      if (jp && jn) begin
         ext_len[i-1] += bsize[31:0] + ext_len[i];
         drop_extent(i);
      end else if (jp) begin
         ext_len[i-1] += bsize[31:0];
      end else if (jn) begin
         ext_start[i] = bstart[31:0];
         ext_len[i] += bsize[31:0];
      end else begin
         for (int k = ext_count; k > i; k--) begin
            ext_start[k] = ext_start[k-1];
            ext_len[k] = ext_len[k-1];
         end
         ext_start[i] = bstart[31:0];
         ext_len[i] = bsize[31:0];
         ext_count++;
      end
      rec_live[slot] = 0;
      used_bytes -= bsize[31:0];
      live_count--;
      return ffa_pkg::ST_OK;
   endfunction

   function void note_request(logic cmd, logic [31:0] rbytes, logic [7:0] align,
                              logic [31:0] faddr);
      logic [1:0]  st;
      logic [31:0] g;
      g = 0;
      if (cmd == ffa_pkg::CMD_ALLOC) st = allocate(rbytes, align, g);
      else st = release_block(faddr);
      want_status.push_back(st);
      want_addr.push_back(g);
      want_used.push_back(used_bytes);
      want_live.push_back(live_count[4:0]);
   endfunction

   function void check_response(logic [1:0] st, logic [31:0] g, logic [31:0] u,
                                logic [4:0] l);
      if (want_status.size() == 0) begin
         $error("response with nothing outstanding");
         errors++;
         return;
      end
      if (st !== want_status[0]) begin
         $error("status expected %0d actual %0d", want_status[0], st);
         errors++;
      end
      if (g !== want_addr[0]) begin
         $error("granted_address expected %h actual %h", want_addr[0], g);
         errors++;
      end
      if (u !== want_used[0]) begin
         $error("bytes_in_use expected %0d actual %0d", want_used[0], u);
         errors++;
      end
      if (l !== want_live[0]) begin
         $error("live_allocations expected %0d actual %0d", want_live[0], l);
         errors++;
      end
      void'(want_status.pop_front());
      void'(want_addr.pop_front());
      void'(want_used.pop_front());
      void'(want_live.pop_front());
   endfunction

   function int outstanding();
      return want_status.size();
   endfunction

   function logic [31:0] pick_live();
      int n;
      n = 0;
      for (int s = 0; s < ffa_pkg::ALLOC_SLOTS; s++) if (rec_live[s]) n++;
      if (n == 0) return pool_base + 8;
      n = $urandom_range(n - 1);
      for (int s = 0; s < ffa_pkg::ALLOC_SLOTS; s++)
         if (rec_live[s]) begin
            if (n == 0) return rec_addr[s];
            n--;
         end
      return 0;
   endfunction
endclass

module tb_first_fit_free_list_allocator_core;
   import ffa_pkg::*;

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_ready;
   logic              req_command = 0;
   logic [31:0]       req_request_bytes = 0;
   logic [7:0]        req_align_bytes = 0;
   logic [31:0]       req_free_address = 0;
   logic              rsp_valid;
   logic              rsp_ready = 0;
   logic [1:0]        rsp_status;
   logic [31:0]       rsp_granted_address;
   logic [31:0]       rsp_bytes_in_use;
   logic [LIVE_W-1:0] rsp_live_allocations;
   logic              csr_write_enable = 0;
   logic [CSR_IDX_W-1:0] csr_index = 0;
   logic [31:0]       csr_write_data = 0;

   alloc_scoreboard   pool_model = new();
   int                cycle_count = 0;
   bit                hold_rsp = 0;
   bit                stim_done = 0;

   first_fit_free_list_allocator_core u_dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2000000) begin
         $display("tb_first_fit_free_list_allocator_core failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         pool_model.check_response(rsp_status, rsp_granted_address, rsp_bytes_in_use,
                                   rsp_live_allocations);
   end

   // receiver: random stalls, with a long hold-off when asked
   initial begin
      int n;
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 0;
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end
         n = $urandom_range(99);
         if (n < 40) begin
            rsp_ready <= 1;
            @(posedge clock);
         end else begin
            rsp_ready <= (n < 80);
            repeat ((n < 95) ? $urandom_range(1, 3) : $urandom_range(10, 60))
               @(posedge clock);
         end
      end
   end

   function int pick_gap();
      int n;
      n = $urandom_range(99);
      if (n < 50) return 0;
      if (n < 93) return $urandom_range(1, 4);
      return $urandom_range(20, 80);
   endfunction

   task automatic send_request(logic cmd, logic [31:0] rbytes, logic [7:0] align,
                               logic [31:0] faddr, int gap);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_command <= cmd;
      req_request_bytes <= rbytes;
      req_align_bytes <= align;
      req_free_address <= faddr;
      do @(posedge clock); while (!req_ready);
      pool_model.note_request(cmd, rbytes, align, faddr);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pool_model.outstanding() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [31:0] value);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      pool_model.write_reg(idx, value);
      csr_write_enable <= 0;
      @(posedge clock);
   endtask

   task automatic random_request(int small_pool);
      logic [31:0] rb;
      int n;
      n = $urandom_range(99);
      if (n < 55) begin
         rb = (small_pool != 0) ? $urandom_range(0, 300) : $urandom_range(0, 4000);
         if ($urandom_range(29) == 0) rb = $urandom;
         send_request(CMD_ALLOC, rb, ($urandom_range(9) == 0) ? 8'($urandom) :
                      8'(1 << $urandom_range(7)), $urandom, pick_gap());
      end else if (n < 92) begin
         send_request(CMD_FREE, $urandom, 8'($urandom), pool_model.pick_live(),
                      pick_gap());
      end else begin
         send_request(CMD_FREE, $urandom, 8'($urandom), $urandom, pick_gap());
      end
   endtask

   initial begin
      logic [31:0] a;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      while (!req_ready) @(posedge clock);

      send_request(CMD_ALLOC, 0, 0, 0, 0);
      send_request(CMD_ALLOC, 100, 8'h80, 0, 0);
      send_request(CMD_ALLOC, 33, 8'd6, 0, 1);
      send_request(CMD_ALLOC, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 0);
      send_request(CMD_FREE, 0, 0, 32'hFFFF_FFFF, 0);
      send_request(CMD_FREE, 0, 0, 32'h0, 0);
      a = pool_model.pick_live();
      send_request(CMD_FREE, 0, 0, a, 0);
      send_request(CMD_FREE, 0, 0, a, 0);
      for (int i = 0; i < 17; i++) send_request(CMD_ALLOC, 20, 8'd4, 0, 0);
      for (int i = 0; i < 16; i += 2)
         send_request(CMD_FREE, 0, 0, pool_model.rec_addr[i], 0);
      drain();

      write_csr(CSR_POOL_BASE, 32'hFFFF_FF00);
      write_csr(CSR_POOL_BYTES, 32'hFFFF_FFFF);
      send_request(CMD_ALLOC, 200, 8'd16, 0, 0);
      send_request(CMD_ALLOC, 32'hFFFF_FFF0, 8'd1, 0, 0);
      drain();
      write_csr(CSR_POOL_BYTES, 8);
      send_request(CMD_ALLOC, 1, 8'd1, 0, 0);
      drain();
      write_csr(CSR_POOL_BASE, 32'h0);
      write_csr(CSR_POOL_BYTES, 0);
      send_request(CMD_ALLOC, 1, 8'd1, 0, 0);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               write_csr(CSR_POOL_BASE, 32'h1000_0003);
               write_csr(CSR_POOL_BYTES, 3000);
            end
            1: begin
               write_csr(CSR_POOL_BASE, $urandom);
               write_csr(CSR_POOL_BYTES, 65536);
            end
            2: begin
               write_csr(CSR_POOL_BASE, 32'hFFFF_F000);
               write_csr(CSR_POOL_BYTES, 32'hFFFF_FFFF);
            end
            default: begin
               write_csr(CSR_POOL_BASE, 32'h5);
               write_csr(CSR_POOL_BYTES, 1500);
            end
         endcase
         if (phase == 1) hold_rsp = 1;
         for (int i = 0; i < 200; i++) random_request((phase == 0 || phase == 3) ? 1 : 0);
         drain();
      end
      stim_done = 1;
      repeat (50) @(posedge clock);
      if (pool_model.outstanding() == 0 && pool_model.errors == 0)
         $display("tb_first_fit_free_list_allocator_core passed");
      else
         $display("tb_first_fit_free_list_allocator_core failed");
      $finish;
   end

endmodule

[sim.f]
src/ffa_pkg.sv
src/ffa_extent_cell.sv
src/ffa_record_table.sv
src/first_fit_free_list_allocator_core.sv
src/ffa_checker.sv
tb/sv/tb_first_fit_free_list_allocator_core.sv
